// ----- src/pcnms_pkg.sv -----
// ----------------------------------------------------------------------------
// pcnms_pkg
// Shared constants for the per-class box suppression block.
// ----------------------------------------------------------------------------
package pcnms_pkg;

  localparam int unsigned MaxDetsDef    = 64;
  localparam int unsigned NumClassesDef = 8;
  localparam int unsigned CoordBitsDef  = 12;

  localparam int unsigned LabelW = 3;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned ThrW   = 16;

  // IoU threshold after reset, Q0.16 (one half)
  localparam logic [ThrW-1:0] ThrReset = 16'd32768;

endpackage

// ----- src/pcnms_det_store.sv -----
// ----------------------------------------------------------------------------
// pcnms_det_store
// Detection memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pcnms_det_store
  import pcnms_pkg::*;
#(
  parameter int unsigned Depth = MaxDetsDef,
  parameter int unsigned Width = 4 * CoordBitsDef + ScoreW + LabelW,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/per_class_box_nms.sv -----
// Frames: a frame ends with the item flagged last; suppression then scans each
//   class over the N stored boxes, with one sweep over them per kept box.
// Throughput: one detection per cycle while loading; no input transfer is taken
//   during suppression. One shared multiplier and one memory read port set the pace.
// Reset: async active low; threshold returns to one half (Q0.16), count to zero.
// ----------------------------------------------------------------------------
// per_class_box_nms
// Greedy per-class non-maximum suppression over one frame of detections.
// ----------------------------------------------------------------------------
module per_class_box_nms
  import pcnms_pkg::*;
#(
  parameter int unsigned MAX_DETS    = MaxDetsDef,
  parameter int unsigned NUM_CLASSES = NumClassesDef,
  parameter int unsigned COORD_BITS  = CoordBitsDef,
  localparam int unsigned IW         = $clog2(MAX_DETS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [ThrW-1:0]       cfg_wdata_i,
  // detection input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] center_x_i,
  input  logic [COORD_BITS-1:0] center_y_i,
  input  logic [COORD_BITS-1:0] box_width_i,
  input  logic [COORD_BITS-1:0] box_height_i,
  input  logic [ScoreW-1:0]     score_i,
  input  logic [LabelW-1:0]     class_label_i,
  input  logic                  last_detection_i,
  // kept detection output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IW-1:0]         kept_index_o,
  output logic [LabelW-1:0]     kept_label_o,
  output logic [ScoreW-1:0]     kept_score_o,
  output logic [COORD_BITS-1:0] kept_center_x_o,
  output logic [COORD_BITS-1:0] kept_center_y_o,
  output logic [COORD_BITS-1:0] kept_width_o,
  output logic [COORD_BITS-1:0] kept_height_o,
  output logic                  last_kept_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned CW   = $clog2(MAX_DETS + 1);
  localparam int unsigned EW   = 4 * CB + ScoreW + LabelW;
  localparam int unsigned AREW = 2 * CB + 1;
  localparam int unsigned PW   = ThrW + AREW;
  localparam int unsigned EDW  = CB + 2;
  // labels are 3 bits wide, so at most eight classes can hold boxes
  localparam int unsigned NCE  = (NUM_CLASSES < 8) ? NUM_CLASSES : 8;
  localparam logic [LabelW-1:0] LastClass = LabelW'(NCE - 1);
  localparam logic [CW-1:0]     MaxCnt    = CW'(MAX_DETS);

  typedef enum logic [12:0] {
    ST_LOAD     = 13'b0000000000001,
    ST_SCAN_RD  = 13'b0000000000010,
    ST_SCAN_CMP = 13'b0000000000100,
    ST_PICK     = 13'b0000000001000,
    ST_AREA     = 13'b0000000010000,
    ST_SUP_RD   = 13'b0000000100000,
    ST_GEO      = 13'b0000001000000,
    ST_MUL_I    = 13'b0000010000000,
    ST_MUL_B    = 13'b0000100000000,
    ST_UNION    = 13'b0001000000000,
    ST_MUL_T    = 13'b0010000000000,
    ST_CMP      = 13'b0100000000000,
    ST_FLUSH    = 13'b1000000000000
  } state_e;

  // control registers
  state_e              state_q, state_d;
  logic [ThrW-1:0]     thr_q, thr_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [LabelW-1:0]   cls_q, cls_d;
  logic                found_q, found_d;
  logic                pend_valid_q, pend_valid_d;
  logic                out_valid_q, out_valid_d;
  logic [MAX_DETS-1:0] removed_q, removed_d;

  // payload registers
  logic [EW-1:0]       best_q, best_d;
  logic [IW-1:0]       best_idx_q, best_idx_d;
  logic [EW-1:0]       pend_q, pend_d;
  logic [IW-1:0]       pend_idx_q, pend_idx_d;
  logic [EW-1:0]       out_q, out_d;
  logic [IW-1:0]       out_idx_q, out_idx_d;
  logic                out_last_q, out_last_d;
  logic [CB-1:0]       iw_q, iw_d, ih_q, ih_d;
  logic [CB-1:0]       sw_q, sw_d, sh_q, sh_d;
  logic [AREW-1:0]     area_a_q, area_a_d;
  logic [AREW-1:0]     area_b_q, area_b_d;
  logic [AREW-1:0]     inter_q, inter_d;
  logic [AREW-1:0]     uni_q, uni_d;
  logic [PW-1:0]       prod_q, prod_d;

  // memory port
  logic          in_acc;
  logic          mem_we;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] rdata;

  // entry fields
  logic [CB-1:0]     a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h;
  logic [LabelW-1:0] b_lbl;
  logic [ScoreW-1:0] a_score, b_score;

  // geometry
  logic signed [EDW-1:0] ax1, ax2, ay1, ay2, bx1, bx2, by1, by2;
  logic signed [EDW-1:0] dx, dy;

  // shared multiplier
  logic [ThrW-1:0] mul_a;
  logic [AREW-1:0] mul_b;
  logic [PW-1:0]   mul_p;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign mem_we    = in_acc && (cnt_q < MaxCnt);
  assign mem_wdata = {class_label_i, score_i, box_height_i, box_width_i,
                      center_y_i, center_x_i};

  pcnms_det_store #(
    .Depth (MAX_DETS),
    .Width (EW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (rdata)
  );

  // field unpacking: a is the kept box, b the entry read back
  assign a_x     = best_q[CB-1:0];
  assign a_y     = best_q[2*CB-1:CB];
  assign a_w     = best_q[3*CB-1:2*CB];
  assign a_h     = best_q[4*CB-1:3*CB];
  assign a_score = best_q[4*CB+ScoreW-1:4*CB];
  assign b_x     = rdata[CB-1:0];
  assign b_y     = rdata[2*CB-1:CB];
  assign b_w     = rdata[3*CB-1:2*CB];
  assign b_h     = rdata[4*CB-1:3*CB];
  assign b_score = rdata[4*CB+ScoreW-1:4*CB];
  assign b_lbl   = rdata[EW-1:4*CB+ScoreW];

  // inclusive edges, center +/- half size
  assign ax1 = $signed({2'b00, a_x}) - $signed({3'b000, a_w[CB-1:1]});
  assign ax2 = $signed({2'b00, a_x}) + $signed({3'b000, a_w[CB-1:1]});
  assign ay1 = $signed({2'b00, a_y}) - $signed({3'b000, a_h[CB-1:1]});
  assign ay2 = $signed({2'b00, a_y}) + $signed({3'b000, a_h[CB-1:1]});
  assign bx1 = $signed({2'b00, b_x}) - $signed({3'b000, b_w[CB-1:1]});
  assign bx2 = $signed({2'b00, b_x}) + $signed({3'b000, b_w[CB-1:1]});
  assign by1 = $signed({2'b00, b_y}) - $signed({3'b000, b_h[CB-1:1]});
  assign by2 = $signed({2'b00, b_y}) + $signed({3'b000, b_h[CB-1:1]});

  // overlap extent: min of right edges - max of left edges + 1
  assign dx = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1) + EDW'(1);
  assign dy = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1) + EDW'(1);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_AREA: begin
        mul_a = ThrW'(a_w | CB'(1));
        mul_b = AREW'(a_h | CB'(1));
      end
      ST_MUL_I: begin
        mul_a = ThrW'(iw_q);
        mul_b = AREW'(ih_q);
      end
      ST_MUL_B: begin
        mul_a = ThrW'(sw_q);
        mul_b = AREW'(sh_q);
      end
      ST_MUL_T: begin
        mul_a = thr_q;
        mul_b = uni_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // sequencer
  always_comb begin
    state_d      = state_q;
    thr_d        = thr_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    cls_d        = cls_q;
    found_d      = found_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    removed_d    = removed_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    out_d        = out_q;
    out_idx_d    = out_idx_q;
    out_last_d   = out_last_q;
    iw_d         = iw_q;
    ih_d         = ih_q;
    sw_d         = sw_q;
    sh_d         = sh_q;
    area_a_d     = area_a_q;
    area_b_d     = area_b_q;
    inter_d      = inter_q;
    uni_d        = uni_q;
    prod_d       = prod_q;

    if (cfg_we_i) begin
      thr_d = cfg_wdata_i;
    end

    case (state_q)
      ST_LOAD: begin
        if (mem_we) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (in_acc && last_detection_i) begin
          removed_d = '0;
          cls_d     = '0;
          idx_d     = '0;
          found_d   = 1'b0;
          state_d   = ST_SCAN_RD;
        end
      end
      // scan for the best remaining box of the current class
      ST_SCAN_RD: begin
        if (idx_q == cnt_q) begin
          state_d = ST_PICK;
        end else if (removed_q[idx_q[IW-1:0]]) begin
          idx_d = idx_q + CW'(1);
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (b_lbl == cls_q && (!found_q || b_score > a_score)) begin
          best_d     = rdata;
          best_idx_d = idx_q[IW-1:0];
          found_d    = 1'b1;
        end
        idx_d   = idx_q + CW'(1);
        state_d = ST_SCAN_RD;
      end
      // keep the winner; the previous keep moves out once the slot is free
      ST_PICK: begin
        if (!found_q) begin
          idx_d = '0;
          if (cls_q == LastClass) begin
            state_d = ST_FLUSH;
          end else begin
            cls_d   = cls_q + LabelW'(1);
            state_d = ST_SCAN_RD;
          end
        end else if (!(pend_valid_q && out_valid_q && out_stall_i)) begin
          if (pend_valid_q) begin
            out_d       = pend_q;
            out_idx_d   = pend_idx_q;
            out_last_d  = 1'b0;
            out_valid_d = 1'b1;
          end
          pend_d                = best_q;
          pend_idx_d            = best_idx_q;
          pend_valid_d          = 1'b1;
          removed_d[best_idx_q] = 1'b1;
          state_d               = ST_AREA;
        end
      end
      ST_AREA: begin
        area_a_d = mul_p[AREW-1:0];
        idx_d    = '0;
        state_d  = ST_SUP_RD;
      end
      // suppression sweep over remaining boxes of this class
      ST_SUP_RD: begin
        if (idx_q == cnt_q) begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = ST_SCAN_RD;
        end else if (removed_q[idx_q[IW-1:0]]) begin
          idx_d = idx_q + CW'(1);
        end else begin
          state_d = ST_GEO;
        end
      end
      ST_GEO: begin
        if (b_lbl != cls_q) begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_SUP_RD;
        end else begin
          iw_d    = (dx > 0) ? dx[CB-1:0] : '0;
          ih_d    = (dy > 0) ? dy[CB-1:0] : '0;
          sw_d    = b_w | CB'(1);
          sh_d    = b_h | CB'(1);
          state_d = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        inter_d = mul_p[AREW-1:0];
        state_d = ST_MUL_B;
      end
      ST_MUL_B: begin
        area_b_d = mul_p[AREW-1:0];
        state_d  = ST_UNION;
      end
      ST_UNION: begin
        uni_d   = area_a_q + area_b_q - inter_q;
        state_d = ST_MUL_T;
      end
      ST_MUL_T: begin
        prod_d  = mul_p;
        state_d = ST_CMP;
      end
      // strict test: inter * 2^16 > thr * union
      ST_CMP: begin
        if ({inter_q, 16'h0000} > PW'(prod_q)) begin
          removed_d[idx_q[IW-1:0]] = 1'b1;
        end
        idx_d   = idx_q + CW'(1);
        state_d = ST_SUP_RD;
      end
      // hand out the final keep with its last mark
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          cnt_d   = '0;
          state_d = ST_LOAD;
        end else if (!(out_valid_q && out_stall_i)) begin
          out_d        = pend_q;
          out_idx_d    = pend_idx_q;
          out_last_d   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          cnt_d        = '0;
          state_d      = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      thr_q        <= ThrReset;
      cnt_q        <= '0;
      idx_q        <= '0;
      cls_q        <= '0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      removed_q    <= '0;
    end else begin
      state_q      <= state_d;
      thr_q        <= thr_d;
      cnt_q        <= cnt_d;
      idx_q        <= idx_d;
      cls_q        <= cls_d;
      found_q      <= found_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      removed_q    <= removed_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    pend_q     <= pend_d;
    pend_idx_q <= pend_idx_d;
    out_q      <= out_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
    iw_q       <= iw_d;
    ih_q       <= ih_d;
    sw_q       <= sw_d;
    sh_q       <= sh_d;
    area_a_q   <= area_a_d;
    area_b_q   <= area_b_d;
    inter_q    <= inter_d;
    uni_q      <= uni_d;
    prod_q     <= prod_d;
  end

  // ports
  assign in_stall_o      = (state_q != ST_LOAD);
  assign out_valid_o     = out_valid_q;
  assign kept_index_o    = out_idx_q;
  assign kept_center_x_o = out_q[CB-1:0];
  assign kept_center_y_o = out_q[2*CB-1:CB];
  assign kept_width_o    = out_q[3*CB-1:2*CB];
  assign kept_height_o   = out_q[4*CB-1:3*CB];
  assign kept_score_o    = out_q[4*CB+ScoreW-1:4*CB];
  assign kept_label_o    = out_q[EW-1:4*CB+ScoreW];
  assign last_kept_o     = out_last_q;

`ifndef SYNTHESIS
  // stored count never exceeds capacity
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt) else $error("stored count above capacity");

  // kept box is marked removed before its sweep starts
  a_keep_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_AREA |-> removed_q[best_idx_q]) else $error("kept box not marked");

  // a frame never ends with a keep still pending
  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && state_d == ST_LOAD) |=> !pend_valid_q)
    else $error("pending keep lost at frame end");

  // results appear only while suppression runs or at its end
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_PICK || state_q == ST_FLUSH))
    else $error("result raised outside keep or flush");
`endif

endmodule

// ----- tb/per_class_box_nms_tb.sv -----
// ----------------------------------------------------------------------------
// per_class_box_nms_tb
// Self-checking bench for per-class greedy box suppression. Frames of
// detections are streamed in bursts. A local model works out the kept boxes
// of each frame, and a monitor compares every output transfer with the
// oldest expected kept box. The threshold is swept between frames.
// ----------------------------------------------------------------------------
module per_class_box_nms_tb
  import pcnms_pkg::*;
;

  localparam int unsigned NDet = MaxDetsDef;
  localparam int unsigned NCls = NumClassesDef;
  localparam int unsigned CW   = CoordBitsDef;
  localparam int unsigned IW   = $clog2(NDet);

  typedef struct packed {
    logic [IW-1:0]     idx;
    logic [LabelW-1:0] label;
    logic [ScoreW-1:0] score;
    logic [CW-1:0]     cx;
    logic [CW-1:0]     cy;
    logic [CW-1:0]     w;
    logic [CW-1:0]     h;
    logic              last;
  } kept_t;

  typedef struct packed {
    logic [CW-1:0]     cx;
    logic [CW-1:0]     cy;
    logic [CW-1:0]     w;
    logic [CW-1:0]     h;
    logic [ScoreW-1:0] score;
    logic [LabelW-1:0] label;
  } det_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [ThrW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CW-1:0]     center_x_i = '0;
  logic [CW-1:0]     center_y_i = '0;
  logic [CW-1:0]     box_width_i = '0;
  logic [CW-1:0]     box_height_i = '0;
  logic [ScoreW-1:0] score_i = '0;
  logic [LabelW-1:0] class_label_i = '0;
  logic              last_detection_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [IW-1:0]     kept_index_o;
  logic [LabelW-1:0] kept_label_o;
  logic [ScoreW-1:0] kept_score_o;
  logic [CW-1:0]     kept_center_x_o;
  logic [CW-1:0]     kept_center_y_o;
  logic [CW-1:0]     kept_width_o;
  logic [CW-1:0]     kept_height_o;
  logic              last_kept_o;

  per_class_box_nms u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .center_x_i, .center_y_i, .box_width_i, .box_height_i, .score_i,
    .class_label_i, .last_detection_i, .out_valid_o, .out_stall_i,
    .kept_index_o, .kept_label_o, .kept_score_o, .kept_center_x_o,
    .kept_center_y_o, .kept_width_o, .kept_height_o, .last_kept_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [ThrW-1:0] thr_q = ThrReset;
  det_t            frame_q[NDet];
  int unsigned     frame_cnt = 0;
  kept_t           kept_q[$];
  int              n_err = 0;
  int unsigned     burst_left = 0;
  int unsigned     stall_mode = 0;

  // overlap test between two stored boxes
  function automatic bit suppresses(det_t a, det_t b, logic [ThrW-1:0] thr);
    longint ahw, ahh, bhw, bhh, iw, ih, inter, ua, ub;
    longint ax1, ax2, ay1, ay2, bx1, bx2, by1, by2;
    ahw = a.w >> 1; ahh = a.h >> 1; bhw = b.w >> 1; bhh = b.h >> 1;
    ax1 = longint'(a.cx) - ahw; ax2 = longint'(a.cx) + ahw;
    ay1 = longint'(a.cy) - ahh; ay2 = longint'(a.cy) + ahh;
    bx1 = longint'(b.cx) - bhw; bx2 = longint'(b.cx) + bhw;
    by1 = longint'(b.cy) - bhh; by2 = longint'(b.cy) + bhh;
    iw = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1) + 1;
    ih = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1) + 1;
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    inter = iw * ih;
    ua = (2 * ahw + 1) * (2 * ahh + 1);
    ub = (2 * bhw + 1) * (2 * bhh + 1);
    return inter * 65536 > longint'(thr) * (ua + ub - inter);
  endfunction

  // store one detection; on the frame end, queue the kept boxes
  task automatic predict_kept(det_t d, bit last);
    bit removed[NDet];
    bit found;
    int best, nk;
    kept_t k;
    if (frame_cnt < NDet) begin
      frame_q[frame_cnt] = d;
      frame_cnt++;
    end
    if (!last) return;
    nk = 0;
    foreach (removed[i]) removed[i] = 1'b0;
    for (int c = 0; c < NCls; c++) begin
      forever begin
        found = 1'b0;
        best = 0;
        for (int i = 0; i < frame_cnt; i++) begin
          if (removed[i] || frame_q[i].label != c) continue;
          if (!found || frame_q[i].score > frame_q[best].score) begin
            best = i;
            found = 1'b1;
          end
        end
        if (!found) break;
        removed[best] = 1'b1;
        k = '{IW'(best), frame_q[best].label, frame_q[best].score,
              frame_q[best].cx, frame_q[best].cy, frame_q[best].w,
              frame_q[best].h, 1'b0};
        kept_q.insert(kept_q.size(), k);
        nk++;
        for (int j = 0; j < frame_cnt; j++)
          if (!removed[j] && frame_q[j].label == c &&
              suppresses(frame_q[best], frame_q[j], thr_q))
            removed[j] = 1'b1;
      end
    end
    if (nk > 0) kept_q[$].last = 1'b1;
    frame_cnt = 0;
  endtask

  // send one detection; sender runs in random bursts with gaps
  task automatic send_det(det_t d, bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    center_x_i       <= d.cx;
    center_y_i       <= d.cy;
    box_width_i      <= d.w;
    box_height_i     <= d.h;
    score_i          <= d.score;
    class_label_i    <= d.label;
    last_detection_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_kept(d, last);
  endtask

  // let the frame drain, then write the threshold
  task automatic set_thr(logic [ThrW-1:0] thr);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (kept_q.size() != 0) @(posedge clk_i);
    repeat (NDet * 8 * 8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thr_q = thr;
  endtask

  function automatic det_t rand_det(int unsigned span);
    det_t d;
    d.cx    = CW'($urandom_range(0, span));
    d.cy    = CW'($urandom_range(0, span));
    d.w     = CW'($urandom_range(0, span));
    d.h     = CW'($urandom_range(0, span));
    d.score = ScoreW'($urandom);
    d.label = LabelW'($urandom_range(0, 3));
    return d;
  endfunction

  // receiver stall pattern: free, random, or heavy stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // compare each output transfer with the oldest kept box
  always @(posedge clk_i) begin
    kept_t got, exp_k;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kept_index_o, kept_label_o, kept_score_o, kept_center_x_o,
              kept_center_y_o, kept_width_o, kept_height_o, last_kept_o};
      if (kept_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected kept box %h", got);
      end else begin
        exp_k = kept_q.pop_front();
        if (got !== exp_k) begin
          n_err++;
          if (n_err <= 10) begin
            $display("kept box mismatch: exp idx=%0d lbl=%0d sc=%h box=%0d,%0d,%0d,%0d last=%b",
                     exp_k.idx, exp_k.label, exp_k.score, exp_k.cx, exp_k.cy,
                     exp_k.w, exp_k.h, exp_k.last);
            $display("  got idx=%0d lbl=%0d sc=%h box=%0d,%0d,%0d,%0d last=%b",
                     got.idx, got.label, got.score, got.cx, got.cy,
                     got.w, got.h, got.last);
          end
        end
      end
    end
  end

  // extremes, ties, equal-IoU boundary, one-box frame
  task automatic test_directed();
    det_t d;
    d = '{12'd100, 12'd100, 12'd10, 12'd10, 16'hFFFF, 3'd0};
    send_det(d, 1'b0);
    send_det(d, 1'b0);                                   // same score tie
    d = '{12'd101, 12'd100, 12'd10, 12'd10, 16'h0000, 3'd0};
    send_det(d, 1'b0);
    d = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'h8000, 3'd7};
    send_det(d, 1'b0);
    d = '{12'h000, 12'h000, 12'hFFF, 12'hFFF, 16'h8000, 3'd7};
    send_det(d, 1'b0);
    d = '{12'h000, 12'h000, 12'h000, 12'h000, 16'h0001, 3'd3};
    send_det(d, 1'b0);
    d = '{12'h555, 12'hAAA, 12'hAAA, 12'h555, 16'h5555, 3'd5};
    send_det(d, 1'b1);
    // identical pair at threshold 1/2: IoU exactly one is above it;
    // half-overlapping boxes one row high test the strict boundary
    d = '{12'd10, 12'd10, 12'd0, 12'd0, 16'd5, 3'd1};
    send_det(d, 1'b0);
    d = '{12'd50, 12'd50, 12'd2, 12'd0, 16'd9, 3'd2};
    send_det(d, 1'b0);
    d = '{12'd51, 12'd50, 12'd2, 12'd0, 16'd8, 3'd2};      // IoU 2/4 == 1/2
    send_det(d, 1'b1);
    // frame with one stored box only
    d = '{12'd7, 12'd7, 12'd3, 12'd3, 16'd1, 3'd6};
    send_det(d, 1'b1);
  endtask

  // a full frame plus overflow items, the last one ignored but ending the frame
  task automatic test_overflow();
    for (int i = 0; i < NDet + 3; i++) send_det(rand_det(4095), i == NDet + 2);
  endtask

  // random frames, mostly small clustered boxes so that overlaps happen
  task automatic test_random(int unsigned items);
    det_t d;
    int unsigned n, flen;
    n = 0;
    while (n < items) begin
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, NDet) :
             $urandom_range(1, 12);
      for (int i = 0; i < flen; i++) begin
        d = ($urandom_range(0, 4) == 0) ? rand_det(4095) : rand_det(63);
        send_det(d, i == flen - 1);
        n++;
      end
      if ($urandom_range(0, 5) == 0) set_thr(ThrW'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_thr(16'd0);
    test_directed();
    set_thr(16'hFFFF);
    test_directed();
    test_overflow();
    set_thr(16'd16384);
    test_random(160);
    if (burst_left != 0) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
    end
    while (kept_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (n_err == 0 && kept_q.size() == 0) begin
      $display("per_class_box_nms_tb passed");
    end else begin
      $display("per_class_box_nms_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("per_class_box_nms_tb failed");
    $finish;
  end

endmodule

// ----- files.f -----
src/pcnms_pkg.sv
src/pcnms_det_store.sv
src/per_class_box_nms.sv
tb/per_class_box_nms_tb.sv
